@@ sv/dq_pkg.sv @@
package dq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int ACT_W      = 3;
  localparam int STAT_W     = 2;

  // slave-side payload: action, value
  localparam int IN_BITS    = ACT_W + DATA_WIDTH;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

  // master-side payload: front, back, count, empty, full, status
  localparam int OUT_BITS   = 2 * DATA_WIDTH + CNT_W + 2 + STAT_W;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ       = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // circular index: a + b, with a below capacity and b at most capacity
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(CAPACITY)) begin
      s = s - (CNT_W + 1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = a - 1'b1;
    end
    return r;
  endfunction

endpackage

@@ sv/double_ended_queue.sv @@
// Bounded double-ended queue of CAPACITY words held in a circular single-port-write,
// single-port-read store, addressed from a front index with an entry count. Each
// transaction on the slave side carries an action (push front, push back, pop front,
// pop back, or read only; unused codes act as read only) and a data word, and yields
// exactly one transaction on the master side with both end values (zero when empty),
// the count, the empty and full flags and a status (done, push dropped because full,
// pop ignored because empty). The end values are kept in registers beside the store,
// so pushes, reads, and pops that fail or leave the queue empty load the output
// directly; other pops first pass through the read state, as the new end value
// comes back through the store's registered read port. A new transaction is taken
// while the previous result waits, if it leaves the output in the same cycle.
module double_ended_queue import dq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IN_W-1:0]  s_axis_tdata,   // action[2:0], value[34:3]
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // front[31:0], back[63:32], count[68:64],
                                           // empty[69], full[70], status[72:71]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                  state_q, state_d;
  logic [IDX_W-1:0]      front_idx_q, front_idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [DATA_WIDTH-1:0] front_val_q, front_val_d;
  logic [DATA_WIDTH-1:0] back_val_q, back_val_d;
  logic                  pend_front_q, pend_front_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q, out_data_d;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;

  logic [ACT_W-1:0]      act;
  logic [DATA_WIDTH-1:0] in_value;
  logic                  accept, out_free, is_full, is_empty, load_out;
  status_e               res_status;

  assign act      = s_axis_tdata[ACT_W-1:0];
  assign in_value = s_axis_tdata[ACT_W +: DATA_WIDTH];
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    state_d      = state_q;
    front_idx_d  = front_idx_q;
    count_d      = count_q;
    front_val_d  = front_val_q;
    back_val_d   = back_val_q;
    pend_front_d = pend_front_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_add(front_idx_q, count_q);
    mem_raddr    = idx_add(front_idx_q, CNT_W'(1));
    load_out     = 1'b0;
    res_status   = ST_DONE;

    if (state_q == ST_READ) begin
      if (pend_front_q) begin
        front_val_d = rd_data_q;
      end else begin
        back_val_d = rd_data_q;
      end
      load_out = 1'b1;
      state_d  = ST_IDLE;
    end else if (accept) begin
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          load_out = 1'b1;
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
            if (act == ACT_PUSH_FRONT) begin
              front_idx_d = idx_prev(front_idx_q);
              mem_waddr   = idx_prev(front_idx_q);
              front_val_d = in_value;
              if (is_empty) begin
                back_val_d = in_value;
              end
            end else begin
              back_val_d = in_value;
              if (is_empty) begin
                front_val_d = in_value;
              end
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
            load_out   = 1'b1;
          end else begin
            count_d = count_q - 1'b1;
            if (act == ACT_POP_FRONT) begin
              front_idx_d = idx_add(front_idx_q, CNT_W'(1));
            end
            if (count_q == CNT_W'(1)) begin
              // queue drains, end values are masked to zero
              load_out = 1'b1;
            end else begin
              mem_re       = 1'b1;
              pend_front_d = (act == ACT_POP_FRONT);
              state_d      = ST_READ;
              if (act == ACT_POP_BACK) begin
                mem_raddr = idx_add(front_idx_q, count_q - CNT_W'(2));
              end
            end
          end
        end
        default: begin
          load_out = 1'b1;
        end
      endcase
    end

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_data_d[OUT_BITS-1:0] = {
        res_status,
        (count_d == CNT_W'(CAPACITY)),
        (count_d == '0),
        count_d,
        (count_d == '0) ? '0 : back_val_d,
        (count_d == '0) ? '0 : front_val_d
      };
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      front_idx_q  <= '0;
      count_q      <= '0;
      pend_front_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_idx_q  <= front_idx_d;
      count_q      <= count_d;
      pend_front_q <= pend_front_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_val_q <= front_val_d;
    back_val_q  <= back_val_d;
    out_data_q  <= out_data_d;
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_value;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ dv/double_ended_queue_checker.sv @@
module double_ended_queue_checker import dq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IN_W-1:0]  s_tdata_i,   // action[2:0], value[34:3]
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [OUT_W-1:0] m_tdata_i,   // front[31:0], back[63:32], count[68:64],
                                        // empty[69], full[70], status[72:71]
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int BACK_LSB   = DATA_WIDTH;
  localparam int COUNT_LSB  = 2 * DATA_WIDTH;
  localparam int EMPTY_BIT  = COUNT_LSB + CNT_W;
  localparam int FULL_BIT   = EMPTY_BIT + 1;
  localparam int STATUS_LSB = FULL_BIT + 1;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
    logic [CNT_W-1:0]      count;
    logic                  empty;
    logic                  full;
    status_e               status;
  } deque_view_t;

  // shadow copy of the queue contents
  logic [DATA_WIDTH-1:0] slot_q [CAPACITY];
  logic [IDX_W-1:0]      head_q;
  logic [CNT_W-1:0]      fill_q;
  deque_view_t           view_q [$];
  int                    result_no;

  function automatic deque_view_t apply_action(input logic [ACT_W-1:0] act,
                                               input logic [DATA_WIDTH-1:0] word);
    deque_view_t v;
    v = '0;
    v.status = ST_DONE;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_q == CNT_W'(CAPACITY)) begin
          v.status = ST_FULL;
        end else if (act == ACT_PUSH_FRONT) begin
          head_q = IDX_W'((int'(head_q) + CAPACITY - 1) % CAPACITY);
          slot_q[head_q] = word;
          fill_q = fill_q + 1'b1;
        end else begin
          slot_q[IDX_W'((int'(head_q) + int'(fill_q)) % CAPACITY)] = word;
          fill_q = fill_q + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill_q == '0) begin
          v.status = ST_EMPTY;
        end else begin
          if (act == ACT_POP_FRONT) begin
            head_q = IDX_W'((int'(head_q) + 1) % CAPACITY);
          end
          fill_q = fill_q - 1'b1;
        end
      end
      default: ; // read only, and the unused codes behave the same
    endcase
    v.count = fill_q;
    v.empty = (fill_q == '0);
    v.full  = (fill_q == CNT_W'(CAPACITY));
    if (fill_q != '0) begin
      v.front = slot_q[head_q];
      v.back  = slot_q[IDX_W'((int'(head_q) + int'(fill_q) - 1) % CAPACITY)];
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deque_view_t got;
    deque_view_t want;
    if (!rst_ni) begin
      head_q = '0;
      fill_q = '0;
      view_q.delete();
      pending_o = 0;
      fail_count_o = 0;
      result_no = 0;
    end else begin
      // a result always trails its transaction, so compare before predicting
      if (m_tvalid_i && m_tready_i) begin
        got.front  = m_tdata_i[0 +: DATA_WIDTH];
        got.back   = m_tdata_i[BACK_LSB +: DATA_WIDTH];
        got.count  = m_tdata_i[COUNT_LSB +: CNT_W];
        got.empty  = m_tdata_i[EMPTY_BIT];
        got.full   = m_tdata_i[FULL_BIT];
        got.status = status_e'(m_tdata_i[STATUS_LSB +: STAT_W]);
        if (view_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_MAX) begin
            $display("result %0d arrived with nothing outstanding: %h", result_no, got);
          end
        end else begin
          want = view_q[0];
          view_q.delete(0);
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_MAX) begin
              $display("result %0d mismatch (expected/actual): front %h/%h back %h/%h",
                       result_no, want.front, got.front, want.back, got.back);
              $display("  count %0d/%0d empty %b/%b full %b/%b status %0d/%0d",
                       want.count, got.count, want.empty, got.empty,
                       want.full, got.full, want.status, got.status);
            end
          end
        end
        result_no++;
      end
      if (s_tvalid_i && s_tready_i) begin
        view_q.insert(view_q.size(),
                      apply_action(s_tdata_i[ACT_W-1:0], s_tdata_i[ACT_W +: DATA_WIDTH]));
      end
      pending_o = view_q.size();
    end
  end

endmodule

@@ dv/double_ended_queue_tb.sv @@
module double_ended_queue_tb import dq_pkg::*; ();

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_MOVES = 1400;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int GAP_MAX      = 12;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;

  int fail_count;
  int pending;
  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int quiet;

  always #1 clk_i = ~clk_i;

  double_ended_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  double_ended_queue_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_axis_tdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int pick_gap_max();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) begin
      return 0;
    end else if (roll == 1) begin
      return 2;
    end
    return GAP_MAX;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  // push_pct steers the fill level so that full and empty are both visited often
  function automatic logic [ACT_W-1:0] pick_action(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      return ACT_W'($urandom_range(int'(ACT_READ) + 1, (1 << ACT_W) - 1));
    end else if (roll < 8) begin
      return ACT_READ;
    end else if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_WIDTH-1:0] word);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= IN_W'({word, act});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    // let the checker record the last transaction before looking at pending
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int moves;
    int seg_left;
    int push_pct;
    logic [ACT_W-1:0] act;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
    // empty queue: a read, then both pops, which are refused
    send_item(ACT_READ, pick_word());
    send_item(ACT_POP_FRONT, pick_word());
    send_item(ACT_POP_BACK, pick_word());
    send_item(ACT_PUSH_BACK, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    send_item(ACT_PUSH_FRONT, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    send_item(ACT_PUSH_BACK, '1);
    send_item(ACT_PUSH_FRONT, '0);
    for (int k = int'(ACT_READ) + 1; k < (1 << ACT_W); k++) begin
      send_item(ACT_W'(k), pick_word());
    end
    send_item(ACT_POP_BACK, pick_word());
    send_item(ACT_POP_FRONT, pick_word());
    send_item(ACT_POP_BACK, pick_word());
    send_item(ACT_POP_FRONT, pick_word());
    send_item(ACT_POP_BACK, pick_word());
    drain_pause();

    moves = 0;
    seg_left = 0;
    push_pct = 50;
    while (moves < RANDOM_MOVES) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 80);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        tx_gap_max = pick_gap_max();
        rx_gap_max = pick_gap_max();
        if ($urandom_range(0, 7) == 0) begin
          drain_pause();
        end
      end
      act = pick_action(push_pct);
      send_item(act, pick_word());
      moves++;
      seg_left--;
    end

    drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
